// ----- rtl/core/acal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acal_pkg
// Shared types, codes and constants of the alternating converter calibration
// sequencer: opcodes, register indexes, sequencer states and command bundle.
// ----------------------------------------------------------------------------
package acal_pkg;

  // fixed field widths
  localparam int TABLE_W     = 60;
  localparam int CFG_DATA_W  = 60;
  localparam int CFG_INDEX_W = 3;
  localparam int VALUE_W     = 16;
  localparam int POWER_W     = 31;
  localparam int RANGE_W     = 3;
  localparam int TICK_W      = 10;
  localparam int CODE_W      = 12;

  // default module parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 12;

  // number of gain ranges; requests above the top one saturate
  localparam int RANGE_COUNT = 5;

  // calibration arithmetic
  localparam int CAL_FRAC     = 10;
  localparam int TEMP_FRAC    = 16;
  localparam int TEMP_FULL    = 4096;
  localparam int AVG_ROUND    = 50;
  // floor divide by 100 via reciprocal on an offset, always positive operand
  localparam int DIV_OFFSET   = 1024;
  localparam int DIV_Y_W      = 18;
  localparam int DIV_MUL_W    = 19;
  localparam int DIV_MUL      = 335545;
  localparam int DIV_SHIFT    = 25;
  localparam int DIV_Q_W      = 12;
  localparam int VALID_LIMIT  = -100;

  // reset values
  localparam logic [5:0]         RANGES_RESET  = 6'd36;
  localparam logic [TICK_W-1:0]  HOLDOFF_RESET = 10'd150;
  localparam logic [TICK_W-1:0]  LEAK_RESET    = 10'd2;
  localparam logic [RANGE_W-1:0] RANGE_RESET   = 3'd4;
  localparam logic [TICK_W-1:0]  TICK_MAX      = 10'd1023;

  // input opcodes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CONV = 2'd1;
  localparam logic [1:0] OP_TEMP = 2'd2;

  // update codes
  localparam logic [1:0] WHICH_NONE = 2'd0;
  localparam logic [1:0] WHICH_VOLT = 2'd1;
  localparam logic [1:0] WHICH_CURR = 2'd2;
  localparam logic [1:0] WHICH_TEMP = 2'd3;

  // converter channel codes
  localparam logic CHAN_CURR = 1'b0;
  localparam logic CHAN_VOLT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLT_BIAS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VOLT_SCALE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURR_BIAS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURR_SCALE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_CAL   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_RANGES     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEAK       = 3'd7;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAGE_A,
    ST_STAGE_B,
    ST_STAGE_C,
    ST_STAGE_D,
    ST_STAGE_E,
    ST_FINISH
  } state_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic step_a;
    logic step_b;
    logic step_c;
    logic step_d;
    logic step_e;
    logic load_out;
  } cmd_t;

endpackage

// ----- rtl/core/acal_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acal_ctrl
// Sequencer: takes one transaction at a time, steps the datapath through its
// stages and owns the result valid flag.
// ----------------------------------------------------------------------------
module acal_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output acal_pkg::cmd_t cmd
);

  acal_pkg::state_t state;
  acal_pkg::state_t state_next;
  logic             out_busy;

  // result register still holds an untaken transaction
  assign out_busy = out_valid && out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      acal_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = acal_pkg::ST_STAGE_A;
        end
      end
      acal_pkg::ST_STAGE_A: state_next = acal_pkg::ST_STAGE_B;
      acal_pkg::ST_STAGE_B: state_next = acal_pkg::ST_STAGE_C;
      acal_pkg::ST_STAGE_C: state_next = acal_pkg::ST_STAGE_D;
      acal_pkg::ST_STAGE_D: state_next = acal_pkg::ST_STAGE_E;
      acal_pkg::ST_STAGE_E: state_next = acal_pkg::ST_FINISH;
      acal_pkg::ST_FINISH: begin
        if (!out_busy) begin
          state_next = acal_pkg::ST_IDLE;
        end
      end
      default: state_next = acal_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      acal_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      acal_pkg::ST_STAGE_A: cmd.step_a = 1'b1;
      acal_pkg::ST_STAGE_B: cmd.step_b = 1'b1;
      acal_pkg::ST_STAGE_C: cmd.step_c = 1'b1;
      acal_pkg::ST_STAGE_D: cmd.step_d = 1'b1;
      acal_pkg::ST_STAGE_E: cmd.step_e = 1'b1;
      acal_pkg::ST_FINISH:  cmd.load_out = !out_busy;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // a new result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  // an accepted transaction starts the stage sequence
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == acal_pkg::ST_STAGE_A))
    else $error("accepted transaction did not start processing");

  // a loaded result is presented on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not flagged valid");

  // no new transaction while stage C runs
  assert property (@(posedge clk) disable iff (rst)
    (state == acal_pkg::ST_STAGE_C) |-> in_stall)
    else $error("input open during processing");

endmodule

// ----- rtl/core/acal_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acal_datapath
// Configuration registers, measurement state, calibration multipliers, the
// temperature running average and the result register.
// ----------------------------------------------------------------------------
module acal_datapath #(
  parameter int SAMPLE_BITS = acal_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = acal_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  acal_pkg::cmd_t                        cmd,
  // configuration writes
  input  logic                                  cfg_write,
  input  logic [acal_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [acal_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input fields
  input  logic [1:0]                            opcode,
  input  logic signed [SAMPLE_BITS-1:0]         adc_sample,
  input  logic [acal_pkg::CODE_W-1:0]           temp_code,
  input  logic                                  load_on,
  // result fields
  output logic signed [acal_pkg::VALUE_W-1:0]   voltage_out,
  output logic signed [acal_pkg::VALUE_W-1:0]   current_out,
  output logic [acal_pkg::POWER_W-1:0]          power_out,
  output logic signed [acal_pkg::VALUE_W-1:0]   temperature_out,
  output logic                                  voltage_valid,
  output logic                                  start_conversion,
  output logic                                  conv_channel,
  output logic [acal_pkg::RANGE_W-1:0]          conv_range,
  output logic [acal_pkg::RANGE_W-1:0]          active_voltage_range,
  output logic [acal_pkg::RANGE_W-1:0]          active_current_range,
  output logic [1:0]                            which_updated
);

  localparam int SUM_W   = ((SAMPLE_BITS > COEF_BITS) ? SAMPLE_BITS : COEF_BITS) + 1;
  localparam int PROD_W  = SUM_W + COEF_BITS + 1;
  localparam int TS_W    = 18;
  localparam int TPROD_W = TS_W + 17;
  localparam int DPROD_W = acal_pkg::DIV_Y_W + acal_pkg::DIV_MUL_W;
  localparam int VW      = acal_pkg::VALUE_W;
  localparam int RW      = acal_pkg::RANGE_W;

  localparam logic signed [PROD_W-1:0]  CAL_HI  = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0]  CAL_LO  = PROD_W'(-32768);
  localparam logic signed [TPROD_W-1:0] TMP_HI  = TPROD_W'(32767);
  localparam logic signed [TPROD_W-1:0] TMP_LO  = TPROD_W'(-32768);
  localparam logic signed [TS_W-1:0]    TS_FULL = TS_W'(acal_pkg::TEMP_FULL);
  localparam logic signed [VW+2:0]      Y_BIAS  =
    (VW+3)'(acal_pkg::AVG_ROUND + 100 * acal_pkg::DIV_OFFSET);
  localparam logic [acal_pkg::DIV_MUL_W-1:0] DIV_M = acal_pkg::DIV_MUL_W'(acal_pkg::DIV_MUL);
  localparam logic signed [VW:0] AVG_HI  = (VW+1)'(32767);
  localparam logic signed [VW:0] AVG_LO  = (VW+1)'(-32768);
  localparam logic signed [VW:0] Q_OFF   = (VW+1)'(acal_pkg::DIV_OFFSET);
  localparam logic signed [VW:0] V_LIMIT = (VW+1)'(acal_pkg::VALID_LIMIT);

  // configuration registers
  logic [acal_pkg::TABLE_W-1:0] volt_bias_table;
  logic [acal_pkg::TABLE_W-1:0] volt_scale_table;
  logic [acal_pkg::TABLE_W-1:0] curr_bias_table;
  logic [acal_pkg::TABLE_W-1:0] curr_scale_table;
  logic [31:0]                  temp_cal;
  logic [5:0]                   requested_ranges;
  logic [acal_pkg::TICK_W-1:0]  holdoff_ticks;
  logic [acal_pkg::TICK_W-1:0]  leak_threshold;

  // measurement state
  logic                          measuring_voltage;
  logic [RW-1:0]                 latched_voltage_range;
  logic [RW-1:0]                 latched_current_range;
  logic [acal_pkg::TICK_W-1:0]   elapsed_ticks;
  logic                          sample_pending;
  logic signed [SAMPLE_BITS-1:0] held_sample;
  logic signed [VW-1:0]          voltage_value;
  logic signed [VW-1:0]          current_value;
  logic signed [VW-1:0]          temperature_value;

  // captured transaction
  logic [1:0]                    op;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [acal_pkg::CODE_W-1:0]   code;
  logic                          load;

  // stage registers
  logic                                consume;
  logic signed [SUM_W-1:0]             cal_sum;
  logic [COEF_BITS-1:0]                cal_scale;
  logic signed [PROD_W-1:0]            cal_prod;
  logic signed [TS_W-1:0]              temp_sum;
  logic signed [TPROD_W-1:0]           temp_prod;
  logic [acal_pkg::DIV_Y_W-1:0]        avg_y;
  logic [DPROD_W-1:0]                  avg_prod;
  logic signed [2*VW-1:0]              power_prod;
  logic                                start;
  logic                                chan;
  logic [RW-1:0]                       crange;
  logic [1:0]                          which;

  // combinational helpers
  logic [acal_pkg::TICK_W-1:0]   elapsed_inc;
  logic [acal_pkg::TICK_W-1:0]   elapsed_n;
  logic                          pending_n;
  logic signed [SAMPLE_BITS-1:0] held_n;
  logic                          consume_n;
  logic signed [COEF_BITS-1:0]   bias_sel;
  logic [COEF_BITS-1:0]          scale_sel;
  logic signed [PROD_W-1:0]      cal_shift;
  logic signed [VW-1:0]          cal_value;
  logic signed [TPROD_W-1:0]     temp_shift;
  logic signed [VW-1:0]          temp_t;
  logic signed [VW+2:0]          y_full;
  logic [acal_pkg::DIV_Q_W-1:0]  avg_q;
  logic signed [VW:0]            avg_new;
  logic signed [VW-1:0]          avg_sat;
  logic [RW-1:0]                 req_volt;
  logic [RW-1:0]                 req_curr;
  logic                          leak_zero;
  logic [2*VW-1:0]               power_abs;

  // packed table entry for one range; ranges past the table read as zero
  function automatic logic [COEF_BITS-1:0] entry(input logic [acal_pkg::TABLE_W-1:0] tab,
                                                 input logic [RW-1:0] r);
    logic [63:0] ext;
    ext = 64'(tab) >> (r * COEF_BITS);
    return ext[COEF_BITS-1:0];
  endfunction

  // requested range saturated to the top range
  function automatic logic [RW-1:0] clamp_range(input logic [RW-1:0] v);
    return (v > RW'(acal_pkg::RANGE_COUNT - 1)) ? RW'(acal_pkg::RANGE_COUNT - 1) : v;
  endfunction

  // stage a: tick and sample bookkeeping, holdoff check, bias add
  always_comb begin
    elapsed_inc = (elapsed_ticks == acal_pkg::TICK_MAX) ? elapsed_ticks
                                                        : elapsed_ticks + 1'b1;
    elapsed_n   = (op == acal_pkg::OP_TICK) ? elapsed_inc : elapsed_ticks;
    pending_n   = (op == acal_pkg::OP_CONV) || sample_pending;
    held_n      = (op == acal_pkg::OP_CONV) ? sample : held_sample;
    consume_n   = ((op == acal_pkg::OP_TICK) || (op == acal_pkg::OP_CONV)) && pending_n &&
                  (elapsed_n >= holdoff_ticks);
    bias_sel    = measuring_voltage ? entry(volt_bias_table, latched_voltage_range)
                                    : entry(curr_bias_table, latched_current_range);
    scale_sel   = measuring_voltage ? entry(volt_scale_table, latched_voltage_range)
                                    : entry(curr_scale_table, latched_current_range);
  end

  // stage c: floor shift and saturation of both products
  always_comb begin
    cal_shift  = cal_prod >>> acal_pkg::CAL_FRAC;
    if (cal_shift > CAL_HI) begin
      cal_value = 16'sh7fff;
    end else if (cal_shift < CAL_LO) begin
      cal_value = -16'sh8000;
    end else begin
      cal_value = VW'(cal_shift);
    end
    temp_shift = temp_prod >>> acal_pkg::TEMP_FRAC;
    if (temp_shift > TMP_HI) begin
      temp_t = 16'sh7fff;
    end else if (temp_shift < TMP_LO) begin
      temp_t = -16'sh8000;
    end else begin
      temp_t = VW'(temp_shift);
    end
    // offset keeps the dividend positive
    y_full   = (VW+3)'(temp_t) - (VW+3)'(temperature_value) + Y_BIAS;
    req_volt = clamp_range(requested_ranges[2:0]);
    req_curr = clamp_range(requested_ranges[5:3]);
  end

  // stage d/e: leak zeroing, running average and power magnitude
  always_comb begin
    leak_zero = !load &&
                ($signed({current_value[VW-1], current_value}) <
                 $signed({7'b0, leak_threshold}));
    avg_q     = avg_prod[acal_pkg::DIV_SHIFT +: acal_pkg::DIV_Q_W];
    avg_new   = (VW+1)'(temperature_value) + $signed({5'b0, avg_q}) - Q_OFF;
    if (avg_new > AVG_HI) begin
      avg_sat = 16'sh7fff;
    end else if (avg_new < AVG_LO) begin
      avg_sat = -16'sh8000;
    end else begin
      avg_sat = VW'(avg_new);
    end
    power_abs = power_prod[2*VW-1] ? (2*VW)'(-power_prod) : power_prod;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_bias_table  <= '0;
      volt_scale_table <= '0;
      curr_bias_table  <= '0;
      curr_scale_table <= '0;
      temp_cal         <= '0;
      requested_ranges <= acal_pkg::RANGES_RESET;
      holdoff_ticks    <= acal_pkg::HOLDOFF_RESET;
      leak_threshold   <= acal_pkg::LEAK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        acal_pkg::CFG_VOLT_BIAS:  volt_bias_table  <= cfg_data;
        acal_pkg::CFG_VOLT_SCALE: volt_scale_table <= cfg_data;
        acal_pkg::CFG_CURR_BIAS:  curr_bias_table  <= cfg_data;
        acal_pkg::CFG_CURR_SCALE: curr_scale_table <= cfg_data;
        acal_pkg::CFG_TEMP_CAL:   temp_cal         <= cfg_data[31:0];
        acal_pkg::CFG_RANGES:     requested_ranges <= cfg_data[5:0];
        acal_pkg::CFG_HOLDOFF:    holdoff_ticks    <= cfg_data[acal_pkg::TICK_W-1:0];
        acal_pkg::CFG_LEAK:       leak_threshold   <= cfg_data[acal_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring_voltage     <= acal_pkg::CHAN_VOLT;
      latched_voltage_range <= acal_pkg::RANGE_RESET;
      latched_current_range <= acal_pkg::RANGE_RESET;
      elapsed_ticks         <= '0;
      sample_pending        <= 1'b0;
      held_sample           <= '0;
      voltage_value         <= '0;
      current_value         <= '0;
      temperature_value     <= '0;
    end else begin
      if (cmd.step_a) begin
        elapsed_ticks  <= consume_n ? '0 : elapsed_n;
        sample_pending <= consume_n ? 1'b0 : pending_n;
        held_sample    <= held_n;
      end
      if (cmd.step_c && consume) begin
        if (measuring_voltage) begin
          voltage_value         <= cal_value;
          latched_current_range <= req_curr;
        end else begin
          current_value         <= cal_value;
          latched_voltage_range <= req_volt;
        end
        measuring_voltage <= !measuring_voltage;
      end
      if (cmd.step_d && leak_zero) begin
        current_value <= '0;
      end
      if (cmd.step_e && (op == acal_pkg::OP_TEMP)) begin
        temperature_value <= avg_sat;
      end
    end
  end

  // captured transaction and stage registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= opcode;
      sample <= adc_sample;
      code   <= temp_code;
      load   <= load_on;
    end
    if (cmd.step_a) begin
      consume   <= consume_n;
      cal_sum   <= SUM_W'(held_n) + SUM_W'(bias_sel);
      cal_scale <= scale_sel;
      temp_sum  <= TS_FULL - $signed({6'b0, code}) + TS_W'($signed(temp_cal[15:0]));
      start     <= 1'b0;
      chan      <= acal_pkg::CHAN_CURR;
      crange    <= '0;
      which     <= (op == acal_pkg::OP_TEMP) ? acal_pkg::WHICH_TEMP : acal_pkg::WHICH_NONE;
    end
    if (cmd.step_b) begin
      cal_prod  <= cal_sum * $signed({1'b0, cal_scale});
      temp_prod <= temp_sum * $signed({1'b0, temp_cal[31:16]});
    end
    if (cmd.step_c) begin
      avg_y <= y_full[acal_pkg::DIV_Y_W-1:0];
      if (consume) begin
        start <= 1'b1;
        if (measuring_voltage) begin
          chan   <= acal_pkg::CHAN_CURR;
          crange <= req_curr;
          which  <= acal_pkg::WHICH_VOLT;
        end else begin
          chan   <= acal_pkg::CHAN_VOLT;
          crange <= req_volt;
          which  <= acal_pkg::WHICH_CURR;
        end
      end
    end
    if (cmd.step_d) begin
      avg_prod <= avg_y * DIV_M;
    end
    if (cmd.step_e) begin
      power_prod <= voltage_value * current_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      voltage_out          <= voltage_value;
      current_out          <= current_value;
      power_out            <= power_abs[acal_pkg::POWER_W-1:0];
      temperature_out      <= temperature_value;
      voltage_valid        <= ((VW+1)'(voltage_value) > V_LIMIT);
      start_conversion     <= start;
      conv_channel         <= chan;
      conv_range           <= crange;
      active_voltage_range <= latched_voltage_range;
      active_current_range <= latched_current_range;
      which_updated        <= which;
    end
  end

endmodule

// ----- rtl/core/alternating_adc_calibration_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_adc_calibration_sequencer
// Measurement front end: holdoff, per-range calibration of an alternating
// voltage/current converter, temperature averaging and power.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one transaction per tick, finished
//   conversion or temperature code. Every input transaction produces exactly
//   one result transaction on the output channel (out_valid/out_stall).
//   Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
//   ready; write it only while no transaction is in flight.
// Sequencing:
//   One input is taken at a time: the next one is accepted only after the
//   finish step has loaded the previous result. out_valid is registered and
//   rises once that load has happened. The sequencer steps A to E run the
//   bias add, the two calibration multipliers, the reciprocal divide of the
//   running average and the power multiplier in turn.
// Stall behavior:
//   The result register holds its transaction while out_stall is high; the
//   next input can still be accepted and processed, and waits in the final
//   step until the result register frees up.
// Reset:
//   rst clears the measurement state and restores configuration defaults;
//   the first conversion is expected on the voltage pair at range 4.
// ----------------------------------------------------------------------------
module alternating_adc_calibration_sequencer #(
  parameter int SAMPLE_BITS = acal_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = acal_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [acal_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [acal_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            opcode,
  input  logic signed [SAMPLE_BITS-1:0]         adc_sample,
  input  logic [acal_pkg::CODE_W-1:0]           temp_code,
  input  logic                                  load_on,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [acal_pkg::VALUE_W-1:0]   voltage_out,
  output logic signed [acal_pkg::VALUE_W-1:0]   current_out,
  output logic [acal_pkg::POWER_W-1:0]          power_out,
  output logic signed [acal_pkg::VALUE_W-1:0]   temperature_out,
  output logic                                  voltage_valid,
  output logic                                  start_conversion,
  output logic                                  conv_channel,
  output logic [acal_pkg::RANGE_W-1:0]          conv_range,
  output logic [acal_pkg::RANGE_W-1:0]          active_voltage_range,
  output logic [acal_pkg::RANGE_W-1:0]          active_current_range,
  output logic [1:0]                            which_updated
);

  acal_pkg::cmd_t cmd;

  // configuration is taken at any time
  assign cfg_ready = 1'b1;

  // sequencer
  acal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  acal_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .cfg_write            (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .opcode               (opcode),
    .adc_sample           (adc_sample),
    .temp_code            (temp_code),
    .load_on              (load_on),
    .voltage_out          (voltage_out),
    .current_out          (current_out),
    .power_out            (power_out),
    .temperature_out      (temperature_out),
    .voltage_valid        (voltage_valid),
    .start_conversion     (start_conversion),
    .conv_channel         (conv_channel),
    .conv_range           (conv_range),
    .active_voltage_range (active_voltage_range),
    .active_current_range (active_current_range),
    .which_updated        (which_updated)
  );

endmodule

// ----- tb/sv/alternating_adc_calibration_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_adc_calibration_sequencer_tb
// Self-checking bench for the measurement sequencer. A clocked driver feeds
// ticks, finished conversions and temperature codes from a queue; a clocked
// monitor predicts every result at acceptance and compares each output
// transaction field by field. Registers are rewritten between phases while
// the block is idle; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module alternating_adc_calibration_sequencer_tb;
  import acal_pkg::*;

  localparam int CW            = COEF_BITS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 120;
  localparam int TIMEOUT_NS    = 3_000_000;

  typedef struct {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] smp;
    logic [CODE_W-1:0]         code;
    logic                      ld;
  } front_end_item_t;

  typedef struct {
    logic signed [VALUE_W-1:0] volt;
    logic signed [VALUE_W-1:0] curr;
    logic [POWER_W-1:0]        power;
    logic signed [VALUE_W-1:0] temp;
    logic                      vvalid;
    logic                      start;
    logic                      chan;
    logic [RANGE_W-1:0]        crange;
    logic [RANGE_W-1:0]        avr;
    logic [RANGE_W-1:0]        acr;
    logic [1:0]                which;
  } reading_t;

  logic clk;
  logic rst = 1'b1;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [1:0]               opcode    = '0;
  logic signed [VALUE_W-1:0] adc_sample = '0;
  logic [CODE_W-1:0]        temp_code = '0;
  logic                     load_on   = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [VALUE_W-1:0] voltage_out;
  logic signed [VALUE_W-1:0] current_out;
  logic [POWER_W-1:0]       power_out;
  logic signed [VALUE_W-1:0] temperature_out;
  logic                     voltage_valid;
  logic                     start_conversion;
  logic                     conv_channel;
  logic [RANGE_W-1:0]       conv_range;
  logic [RANGE_W-1:0]       active_voltage_range;
  logic [RANGE_W-1:0]       active_current_range;
  logic [1:0]               which_updated;

  alternating_adc_calibration_sequencer DUT (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .opcode               (opcode),
    .adc_sample           (adc_sample),
    .temp_code            (temp_code),
    .load_on              (load_on),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .voltage_out          (voltage_out),
    .current_out          (current_out),
    .power_out            (power_out),
    .temperature_out      (temperature_out),
    .voltage_valid        (voltage_valid),
    .start_conversion     (start_conversion),
    .conv_channel         (conv_channel),
    .conv_range           (conv_range),
    .active_voltage_range (active_voltage_range),
    .active_current_range (active_current_range),
    .which_updated        (which_updated)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("alternating_adc_calibration_sequencer_tb: done, errors");
    $finish;
  end

  // predicted measurement state and register copies
  logic [TABLE_W-1:0]        vbias_tab, vgain_tab, cbias_tab, cgain_tab;
  logic [31:0]               temp_cal_reg;
  logic [5:0]                range_req;
  logic [TICK_W-1:0]         holdoff_cfg, leak_cfg;
  logic                      on_voltage, have_sample;
  logic [RANGE_W-1:0]        volt_rng, curr_rng;
  logic [TICK_W-1:0]         tick_count;
  logic signed [VALUE_W-1:0] held_smp, volt_mv, curr_ma, temp_avg;

  front_end_item_t pending_items[$];
  reading_t        predicted_readings[$];
  front_end_item_t offer;
  reading_t        want_r, got_r;

  logic in_fire = 1'b0;
  logic rx_hold = 1'b0;
  int   tx_idle_pct  = 23;
  int   rx_stall_pct = 23;
  int   hold_cnt     = 0;
  int   n_queued = 0, n_accepted = 0, n_results = 0, n_errors = 0;
  int   n_conv = 0, n_temp = 0, n_writes = 0;

  task automatic reset_model();
    vbias_tab    = '0;
    vgain_tab    = '0;
    cbias_tab    = '0;
    cgain_tab    = '0;
    temp_cal_reg = '0;
    range_req    = RANGES_RESET;
    holdoff_cfg  = HOLDOFF_RESET;
    leak_cfg     = LEAK_RESET;
    on_voltage   = 1'b1;
    have_sample  = 1'b0;
    volt_rng     = RANGE_RESET;
    curr_rng     = RANGE_RESET;
    tick_count   = '0;
    held_smp     = '0;
    volt_mv      = '0;
    curr_ma      = '0;
    temp_avg     = '0;
  endtask

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    n_writes++;
    case (idx)
      CFG_VOLT_BIAS:  vbias_tab    = d;
      CFG_VOLT_SCALE: vgain_tab    = d;
      CFG_CURR_BIAS:  cbias_tab    = d;
      CFG_CURR_SCALE: cgain_tab    = d;
      CFG_TEMP_CAL:   temp_cal_reg = d[31:0];
      CFG_RANGES:     range_req    = d[5:0];
      CFG_HOLDOFF:    holdoff_cfg  = d[TICK_W-1:0];
      CFG_LEAK:       leak_cfg     = d[TICK_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] sat16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic [RANGE_W-1:0] clamp_range(logic [RANGE_W-1:0] r);
    return (r > 3'(RANGE_COUNT - 1)) ? 3'(RANGE_COUNT - 1) : r;
  endfunction

  // (sample + bias) * gain, floored by 2^10, saturated
  function automatic logic signed [VALUE_W-1:0] apply_gain(logic signed [VALUE_W-1:0] smp,
      logic [TABLE_W-1:0] btab, logic [TABLE_W-1:0] gtab, logic [RANGE_W-1:0] r);
    longint bias, gain;
    bias = longint'($signed(btab[r*CW +: CW]));
    gain = longint'(gtab[r*CW +: CW]);
    return sat16(((longint'(smp) + bias) * gain) >>> CAL_FRAC);
  endfunction

  // one input transaction in, one reading out
  function automatic reading_t predict_reading(front_end_item_t it);
    reading_t r;
    longint   s, sc, t, num, q, pw;
    r = '{default: '0};
    if (it.op == OP_TICK) begin
      if (tick_count != TICK_MAX) tick_count++;
    end else if (it.op == OP_CONV) begin
      held_smp    = it.smp;
      have_sample = 1'b1;
    end else if (it.op == OP_TEMP) begin
      s  = TEMP_FULL - longint'(it.code) + longint'($signed(temp_cal_reg[15:0]));
      sc = longint'(temp_cal_reg[31:16]);
      t  = sat16((s * sc) >>> TEMP_FRAC);
      num = longint'(temp_avg) * 99 + t + AVG_ROUND;
      q  = (num >= 0) ? num / 100 : -((-num + 99) / 100);
      temp_avg = sat16(q);
      r.which  = WHICH_TEMP;
    end

    // held conversion is used once the holdoff has run out
    if ((it.op == OP_TICK || it.op == OP_CONV) && have_sample && tick_count >= holdoff_cfg) begin
      if (on_voltage) begin
        volt_mv  = apply_gain(held_smp, vbias_tab, vgain_tab, volt_rng);
        curr_rng = clamp_range(range_req[5:3]);
        r.chan   = CHAN_CURR;
        r.crange = curr_rng;
        r.which  = WHICH_VOLT;
      end else begin
        curr_ma  = apply_gain(held_smp, cbias_tab, cgain_tab, curr_rng);
        volt_rng = clamp_range(range_req[2:0]);
        r.chan   = CHAN_VOLT;
        r.crange = volt_rng;
        r.which  = WHICH_CURR;
      end
      on_voltage  = !on_voltage;
      r.start     = 1'b1;
      have_sample = 1'b0;
      tick_count  = '0;
    end

    // leak zeroing with the load off
    if (!it.ld && longint'(curr_ma) < longint'(leak_cfg)) curr_ma = '0;

    pw = longint'(volt_mv) * longint'(curr_ma);
    if (pw < 0) pw = -pw;
    r.volt   = volt_mv;
    r.curr   = curr_ma;
    r.power  = POWER_W'(pw);
    r.temp   = temp_avg;
    r.vvalid = longint'(volt_mv) > VALID_LIMIT;
    r.avr    = volt_rng;
    r.acr    = curr_rng;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_reading(reading_t w, reading_t g);
    check_field("voltage_out", w.volt, g.volt);
    check_field("current_out", w.curr, g.curr);
    check_field("power_out", w.power, g.power);
    check_field("temperature_out", w.temp, g.temp);
    check_field("voltage_valid", w.vvalid, g.vvalid);
    check_field("start_conversion", w.start, g.start);
    check_field("conv_channel", w.chan, g.chan);
    check_field("conv_range", w.crange, g.crange);
    check_field("active_voltage_range", w.avr, g.avr);
    check_field("active_current_range", w.acr, g.acr);
    check_field("which_updated", w.which, g.which);
  endtask

  // input driver: next transaction at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offer = pending_items.pop_front();
        in_valid   <= 1'b1;
        opcode     <= offer.op;
        adc_sample <= offer.smp;
        temp_code  <= offer.code;
        load_on    <= offer.ld;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random, plus one long hold-off when asked
  always @(negedge clk) begin
    if (rx_hold && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // monitor: register writes, accepted inputs and results at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        predicted_readings.push_back(predict_reading(offer));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        got_r = '{volt: voltage_out, curr: current_out, power: power_out,
                  temp: temperature_out, vvalid: voltage_valid, start: start_conversion,
                  chan: conv_channel, crange: conv_range, avr: active_voltage_range,
                  acr: active_current_range, which: which_updated};
        if (predicted_readings.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("%0t: result with no transaction pending", $time);
        end else begin
          want_r = predicted_readings.pop_front();
          check_reading(want_r, got_r);
          n_results++;
          if (want_r.start) n_conv++;
          if (want_r.which == WHICH_TEMP) n_temp++;
        end
      end
    end
  end

  function automatic void queue_item(logic [1:0] op, logic signed [VALUE_W-1:0] smp,
      logic [CODE_W-1:0] code, logic ld);
    pending_items.push_back('{op: op, smp: smp, code: code, ld: ld});
    n_queued++;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [TABLE_W-1:0] rand_table();
    logic [TABLE_W-1:0] t;
    for (int r = 0; r < RANGE_COUNT; r++) begin
      case ($urandom_range(5))
        0:       t[r*CW +: CW] = 12'h400;
        1:       t[r*CW +: CW] = 12'($urandom_range(15));
        2:       t[r*CW +: CW] = 12'h7FF;
        3:       t[r*CW +: CW] = 12'h800;
        default: t[r*CW +: CW] = 12'($urandom);
      endcase
    end
    return t;
  endfunction

  function automatic logic [TABLE_W-1:0] pack_table(logic [CW-1:0] e0, e1, e2, e3, e4);
    return {e4, e3, e2, e1, e0};
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [TABLE_W-1:0] vb, vs, cb, cs, input logic [31:0] tc,
      input logic [5:0] rg, input logic [TICK_W-1:0] ho, lk);
    write_reg(CFG_VOLT_BIAS, vb);
    write_reg(CFG_VOLT_SCALE, vs);
    write_reg(CFG_CURR_BIAS, cb);
    write_reg(CFG_CURR_SCALE, cs);
    write_reg(CFG_TEMP_CAL, tc);
    write_reg(CFG_RANGES, rg);
    write_reg(CFG_HOLDOFF, ho);
    write_reg(CFG_LEAK, lk);
  endtask

  // kind 1 full-scale, kind 2 all-zero, any other kind random register settings
  task automatic configure_phase(int kind);
    case (kind)
      1: set_all({TABLE_W{1'b1}}, {TABLE_W{1'b1}}, {TABLE_W{1'b1}}, {TABLE_W{1'b1}},
                 32'hFFFF_FFFF, 6'd63, 10'd0, 10'd1023);
      2: set_all('0, '0, '0, '0, 32'h0, 6'd0, 10'd0, 10'd0);
      default: set_all(rand_table(), rand_table(), rand_table(), rand_table(), $urandom,
                       6'($urandom_range(63)),
                       10'((kind == 5) ? $urandom_range(40) : $urandom_range(8)),
                       10'($urandom_range(1) ? $urandom_range(20) : $urandom_range(1023)));
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || predicted_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly conversion-then-holdoff sequences, with temperature and noise mixed in
  task automatic queue_random(int n);
    int left, ticks;
    left = n;
    while (left > 0) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          queue_item(OP_CONV, rand_sample(), rand_code(), 1'($urandom_range(1)));
          ticks = int'(holdoff_cfg) + $urandom_range(1);
          for (int k = 0; k < ticks; k++)
            queue_item(OP_TICK, rand_sample(), rand_code(), 1'($urandom_range(1)));
          left -= ticks + 1;
        end
        4: begin
          // newer completion replaces the held one
          queue_item(OP_CONV, rand_sample(), rand_code(), 1'($urandom_range(1)));
          queue_item(OP_CONV, rand_sample(), rand_code(), 1'($urandom_range(1)));
          ticks = int'(holdoff_cfg);
          for (int k = 0; k < ticks; k++)
            queue_item(OP_TICK, rand_sample(), rand_code(), 1'($urandom_range(1)));
          left -= ticks + 2;
        end
        5, 6: begin
          queue_item(OP_TEMP, rand_sample(), rand_code(), 1'($urandom_range(1)));
          left--;
        end
        default: begin
          queue_item($urandom_range(1) ? OP_TICK : OP_CONV, rand_sample(), rand_code(),
                     1'($urandom_range(1)));
          left--;
        end
      endcase
    end
  endtask

  // stimulus
  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset defaults: long holdoff, zero tables
    queue_item(OP_TEMP, '0, 12'h000, 1'b1);
    queue_item(OP_CONV, 16'sh7FFF, 12'hFFF, 1'b1);
    queue_item(OP_TICK, 16'sh8000, 12'h000, 1'b0);
    wait_drained();

    // extreme coefficients, saturating range requests, short holdoff, high leak
    set_all(pack_table(12'h7FF, 12'h800, 12'hFFF, 12'h000, 12'h001),
            pack_table(12'hFFF, 12'h000, 12'h400, 12'h001, 12'hFFF),
            pack_table(12'h000, 12'h7FF, 12'h001, 12'hFFF, 12'h800),
            pack_table(12'h001, 12'h400, 12'hFFF, 12'h000, 12'h400),
            32'hFFFF_8000, 6'd63, 10'd2, 10'd1023);
    queue_item(OP_CONV, 16'sh7FFF, 12'h000, 1'b1);
    queue_item(OP_CONV, 16'sh8000, 12'h000, 1'b1);
    queue_item(OP_TICK, '0, 12'h000, 1'b1);
    queue_item(OP_TICK, '0, 12'h000, 1'b1);
    queue_item(OP_TEMP, '0, 12'h000, 1'b1);
    queue_item(OP_TEMP, '0, 12'hFFF, 1'b0);
    queue_item(OP_CONV, 16'sd100, 12'h000, 1'b0);
    queue_item(OP_TICK, '0, 12'h000, 1'b0);
    queue_item(OP_TICK, '0, 12'h000, 1'b0);
    queue_item(OP_CONV, 16'sh7FFF, 12'h000, 1'b1);
    queue_item(OP_TICK, '0, 12'h000, 1'b1);
    queue_item(OP_TICK, '0, 12'h000, 1'b1);
    queue_item(OP_CONV, 16'sd5, 12'h000, 1'b1);
    queue_item(OP_TICK, '0, 12'h000, 1'b0);
    queue_item(OP_TICK, '0, 12'h000, 1'b0);
    wait_drained();

    // zero holdoff: a completion is used at once; range 0 on both channels
    write_reg(CFG_HOLDOFF, '0);
    write_reg(CFG_RANGES, '0);
    write_reg(CFG_LEAK, '0);
    queue_item(OP_CONV, 16'sh7FFF, 12'h000, 1'b1);
    queue_item(OP_CONV, 16'sh8000, 12'h000, 1'b0);
    queue_item(OP_CONV, '0, 12'h000, 1'b0);
    queue_item(OP_TICK, '0, 12'h000, 1'b0);
    queue_item(OP_TEMP, '0, 12'h800, 1'b1);
    wait_drained();

    // random phases; phase 3 never idles, phase 4 holds the receiver off
    for (int ph = 0; ph < 6; ph++) begin
      configure_phase(ph);
      tx_idle_pct  = (ph == 3 || ph == 4) ? 0 : 23;
      rx_stall_pct = (ph == 3) ? 0 : 23;
      if (ph == 4) rx_hold = 1'b1;
      queue_random(145);
      wait_drained();
    end
    tx_idle_pct  = 23;
    rx_stall_pct = 23;

    n_errors += predicted_readings.size();
    $display("checked %0d results: %0d conversions used, %0d temperature updates",
             n_results, n_conv, n_temp);
    $display("%0d register writes, holdoff from 0 to the reset value, one %0d-cycle hold-off",
             n_writes, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("alternating_adc_calibration_sequencer_tb: done, clean");
    end else begin
      $display("alternating_adc_calibration_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
